FILE: design/ogr_pkg.sv
// Shared types, constants and register codes for the occupancy grid ray update core.
`default_nettype none
package ogr_pkg;

    // Grid geometry and stamp reach
    localparam int GRID_WIDTH  = 256;
    localparam int GRID_HEIGHT = 256;
    localparam int MAX_RADIUS  = 2;

    localparam int DEPTH     = GRID_WIDTH * GRID_HEIGHT;
    localparam int X_BITS    = $clog2(GRID_WIDTH);
    localparam int Y_BITS    = $clog2(GRID_HEIGHT);
    localparam int ADDR_BITS = $clog2(DEPTH);

    // Signed cell difference to the robot cell, squared distance and its root
    localparam int MAXXY     = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
    localparam int SPAN_BITS = ((MAXXY > 8) ? MAXXY : 8) + 1;
    localparam int D2_BITS   = 2 * SPAN_BITS;
    localparam int ROOT_BITS = SPAN_BITS;

    // Ray walk coordinates and Bresenham error term
    localparam int POS_W = 18;
    localparam int ERR_W = 20;

    // Stamp offsets
    localparam int OFF_W = 4;

    // Arithmetic widths
    localparam int SCALE_W = 16 + ROOT_BITS + 2;
    localparam int INC_W   = 25;
    localparam int PROD_W  = INC_W + SCALE_W;
    localparam int DELTA_W = PROD_W - 16;
    localparam int SUM_W   = DELTA_W + 1;

    localparam logic signed [POS_W-1:0]   GRID_W_POS = POS_W'(GRID_WIDTH);
    localparam logic signed [POS_W-1:0]   GRID_H_POS = POS_W'(GRID_HEIGHT);
    localparam logic signed [OFF_W-1:0]   RAD_POS    = OFF_W'(MAX_RADIUS);
    localparam logic signed [OFF_W-1:0]   RAD_NEG    = -OFF_W'(MAX_RADIUS);
    localparam logic signed [SCALE_W-1:0] SCALE_ONE  = SCALE_W'(65536);
    localparam logic signed [PROD_W-1:0]  HALF_FREE  = PROD_W'(32768);
    localparam logic signed [PROD_W-1:0]  HALF_OCC   = PROD_W'(8388608);

    // Configuration register indexes
    localparam logic [2:0] CFG_FREE_INC   = 3'd0;
    localparam logic [2:0] CFG_OCC_INC    = 3'd1;
    localparam logic [2:0] CFG_DIST_FACT  = 3'd2;
    localparam logic [2:0] CFG_CLAMP_LOW  = 3'd3;
    localparam logic [2:0] CFG_CLAMP_HIGH = 3'd4;
    localparam logic [2:0] CFG_GAUSS      = 3'd5;
    localparam logic [2:0] CFG_OCC_LEVEL  = 3'd6;
    localparam logic [2:0] CFG_FREE_LEVEL = 3'd7;

    // Cell classes
    localparam logic [1:0] CLASS_FREE     = 2'd0;
    localparam logic [1:0] CLASS_UNKNOWN  = 2'd1;
    localparam logic [1:0] CLASS_OCCUPIED = 2'd2;

    // Item modes
    localparam logic MODE_RAY  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [7:0]         start_x;
        logic [7:0]         start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic               is_hit;
    } req_t;

    typedef struct packed {
        logic signed [15:0] cell_value;
        logic [1:0]         cell_class;
        logic [15:0]        cells_touched;
    } rsp_t;

endpackage
`default_nettype wire

FILE: design/occupancy_grid_ray_update_core.sv
// Top level of the occupancy grid ray update core: sequencer, arithmetic and grid memory.
//
// Log-odds occupancy grid (Q8.8) held in one single-port-style synchronous memory.
// Channels: req (valid/ready) takes one item, either a ray or a cell read; rsp
// (valid/ready) returns exactly one item per request; cfg (valid/ready, always
// ready) writes one of eight registers by index.
// A read passes S_READ and S_DONE after it is accepted, and req_ready returns
// with the result, so a new read is taken only once the last is done. A ray walks its
// Bresenham line one cell per cycle while its cells lie off the grid; each in-grid
// cell takes a read, a bit-serial integer square root, scale multiply, increment
// multiply, rounding, clamp and write back. A hit adds up to 25 stamp cells with
// the same steps, and a skipped offset passes only the stamp step. The walk loop and the
// shared square root unit set the rate; after its walk cells, a ray ends with the
// end check, the stamp exit (with a hit) and the finish step.
// One item is in flight at a time; the next item is taken once the current
// result sits in the output register, even if the receiver has not taken it.
// When rsp_ready is low, the finished result waits in the output register and
// the sequencer holds until that register frees.
// Reset: control and configuration registers return to defaults, then a clearing
// pass writes zero to every cell of the 256 x 256 grid, one cell per cycle;
// req_ready stays low during that pass. Configuration writes are taken anytime.
`default_nettype none
module occupancy_grid_ray_update_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire ogr_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output ogr_pkg::rsp_t      rsp,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [63:0]   cfg_data
);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_READ  = 11'b00000000100,
        S_WALK  = 11'b00000001000,
        S_STAMP = 11'b00000010000,
        S_SQRT  = 11'b00000100000,
        S_SCALE = 11'b00001000000,
        S_MULT  = 11'b00010000000,
        S_ROUND = 11'b00100000000,
        S_WRITE = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic signed [15:0] free_inc_reg, occ_inc_reg, clamp_low_reg;
    logic signed [15:0] occ_level_reg, free_level_reg;
    logic [15:0]        dist_factor_reg;
    logic [14:0]        clamp_high_reg;
    logic [63:0]        gauss_reg;

    // Item and walk state
    logic [ogr_pkg::ADDR_BITS-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                               hit_reg, hit_next;
    logic [7:0]                         rx_reg, rx_next, ry_reg, ry_next;
    logic signed [ogr_pkg::POS_W-1:0]   ex_reg, ex_next, ey_reg, ey_next;
    logic signed [ogr_pkg::POS_W-1:0]   x_reg, x_next, y_reg, y_next;
    logic signed [ogr_pkg::ERR_W-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic signed [ogr_pkg::ERR_W-1:0]   err_reg, err_next;
    logic                               sxn_reg, sxn_next, syn_reg, syn_next;
    logic signed [ogr_pkg::OFF_W-1:0]   ox_reg, ox_next, oy_reg, oy_next;
    logic                               stamp_reg, stamp_next;
    logic                               rd_in_reg, rd_in_next;

    // Arithmetic pipeline
    logic signed [ogr_pkg::INC_W-1:0]   inc_reg, inc_next;
    logic [ogr_pkg::D2_BITS-1:0]        rem_reg, rem_next, root_reg, root_next;
    logic [ogr_pkg::D2_BITS-1:0]        bit_reg, bit_next;
    logic signed [ogr_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic signed [ogr_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic signed [ogr_pkg::DELTA_W-1:0] delta_reg, delta_next;
    logic [ogr_pkg::ADDR_BITS-1:0]      waddr_reg, waddr_next;
    logic [15:0]                        touched_reg, touched_next;

    // Result
    logic signed [15:0] value_reg, value_next;
    logic [1:0]         class_reg, class_next;
    ogr_pkg::rsp_t      rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // Grid memory
    logic signed [15:0]            grid_mem [ogr_pkg::DEPTH];
    logic signed [15:0]            mem_q_reg;
    logic                          mem_re, mem_we;
    logic [ogr_pkg::ADDR_BITS-1:0] mem_raddr, mem_waddr;
    logic signed [15:0]            mem_wdata;

    // Shared cell address and distance logic
    logic signed [ogr_pkg::POS_W-1:0]     cell_x, cell_y;
    logic                                 cell_in;
    logic [ogr_pkg::ADDR_BITS-1:0]        cell_addr;
    logic signed [ogr_pkg::SPAN_BITS-1:0] ddx, ddy;
    logic signed [ogr_pkg::D2_BITS-1:0]   sqx, sqy;
    logic [ogr_pkg::D2_BITS-1:0]          cell_d2;

    // Stamp weight
    logic signed [ogr_pkg::OFF_W-1:0] oxx, oyy;
    logic [4:0]                       od2;
    logic [2:0]                       wsel;
    logic [8:0]                       wgt;
    logic signed [9:0]                wgt_s;

    // Walk step, root step, rounding and clamp
    logic signed [ogr_pkg::ERR_W-1:0]   e2;
    logic [ogr_pkg::D2_BITS-1:0]        trial;
    logic [16+ogr_pkg::ROOT_BITS-1:0]   dfd;
    logic signed [ogr_pkg::PROD_W-1:0]  rnd, shifted;
    logic signed [ogr_pkg::SUM_W-1:0]   sum, clamped;
    logic signed [ogr_pkg::POS_W-1:0]   ex_in, ey_in, x_in, y_in;
    logic                               req_fire;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Pick the cell under work: stamp offset, walk position or read address
    always_comb
    begin
        cell_x = ex_reg + ogr_pkg::POS_W'(ox_reg);
        cell_y = ey_reg + ogr_pkg::POS_W'(oy_reg);
        if (state_reg == S_WALK)
        begin
            cell_x = x_reg;
            cell_y = y_reg;
        end
        else if (state_reg == S_IDLE)
        begin
            cell_x = ogr_pkg::POS_W'(req.start_x);
            cell_y = ogr_pkg::POS_W'(req.start_y);
        end
        cell_in = (cell_x >= 0) && (cell_x < ogr_pkg::GRID_W_POS) &&
                  (cell_y >= 0) && (cell_y < ogr_pkg::GRID_H_POS);
        cell_addr = ogr_pkg::ADDR_BITS'(cell_y[ogr_pkg::Y_BITS-1:0]) *
                    ogr_pkg::ADDR_BITS'(ogr_pkg::GRID_WIDTH) +
                    ogr_pkg::ADDR_BITS'(cell_x[ogr_pkg::X_BITS-1:0]);
        ddx = cell_x[ogr_pkg::SPAN_BITS-1:0] - ogr_pkg::SPAN_BITS'(rx_reg);
        ddy = cell_y[ogr_pkg::SPAN_BITS-1:0] - ogr_pkg::SPAN_BITS'(ry_reg);
        sqx = ogr_pkg::D2_BITS'(ddx) * ogr_pkg::D2_BITS'(ddx);
        sqy = ogr_pkg::D2_BITS'(ddy) * ogr_pkg::D2_BITS'(ddy);
        cell_d2 = sqx + sqy;
    end

    // Gaussian weight by squared offset; zero for a squared offset above 8
    always_comb
    begin
        oxx   = ox_reg * ox_reg;
        oyy   = oy_reg * oy_reg;
        od2   = 5'(oxx) + 5'(oyy);
        wsel  = 3'(od2 - 5'd1);
        if (od2 == 5'd0)
            wgt = 9'd256;
        else if (od2 <= 5'd8)
            wgt = {1'b0, gauss_reg[{wsel, 3'b000} +: 8]};
        else
            wgt = 9'd0;
        wgt_s = {1'b0, wgt};
    end

    always_comb
    begin
        e2      = err_reg <<< 1;
        trial   = root_reg + bit_reg;
        dfd     = dist_factor_reg * root_reg[ogr_pkg::ROOT_BITS-1:0];
        rnd     = prod_reg + (stamp_reg ? ogr_pkg::HALF_OCC : ogr_pkg::HALF_FREE);
        shifted = stamp_reg ? (rnd >>> 24) : (rnd >>> 16);
        sum     = ogr_pkg::SUM_W'(mem_q_reg) + ogr_pkg::SUM_W'(delta_reg);
        clamped = sum;
        if (clamped < ogr_pkg::SUM_W'(clamp_low_reg))
            clamped = ogr_pkg::SUM_W'(clamp_low_reg);
        if (clamped > ogr_pkg::SUM_W'(signed'({1'b0, clamp_high_reg})))
            clamped = ogr_pkg::SUM_W'(signed'({1'b0, clamp_high_reg}));
        ex_in = ogr_pkg::POS_W'(req.end_x);
        ey_in = ogr_pkg::POS_W'(req.end_y);
        x_in  = ogr_pkg::POS_W'(req.start_x);
        y_in  = ogr_pkg::POS_W'(req.start_y);
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        hit_next       = hit_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        err_next       = err_reg;
        sxn_next       = sxn_reg;
        syn_next       = syn_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        stamp_next     = stamp_reg;
        rd_in_next     = rd_in_reg;
        inc_next       = inc_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        scale_next     = scale_reg;
        prod_next      = prod_reg;
        delta_next     = delta_reg;
        waddr_next     = waddr_reg;
        touched_next   = touched_reg;
        value_next     = value_reg;
        class_next     = class_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        mem_re         = 1'b0;
        mem_raddr      = cell_addr;
        mem_we         = 1'b0;
        mem_waddr      = waddr_reg;
        mem_wdata      = 16'(clamped);

        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = 16'sd0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ogr_pkg::ADDR_BITS'(ogr_pkg::DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    rx_next      = req.start_x;
                    ry_next      = req.start_y;
                    hit_next     = req.is_hit;
                    touched_next = 16'd0;
                    value_next   = 16'sd0;
                    class_next   = ogr_pkg::CLASS_FREE;
                    if (req.mode == ogr_pkg::MODE_READ)
                    begin
                        mem_re     = cell_in;
                        rd_in_next = cell_in;
                        state_next = S_READ;
                    end
                    else
                    begin
                        // Set up the Bresenham walk
                        ex_next  = ex_in;
                        ey_next  = ey_in;
                        x_next   = x_in;
                        y_next   = y_in;
                        sxn_next = !(x_in < ex_in);
                        syn_next = !(y_in < ey_in);
                        dx_next  = (ex_in > x_in) ? ogr_pkg::ERR_W'(ex_in - x_in)
                                                  : ogr_pkg::ERR_W'(x_in - ex_in);
                        dy_next  = (ey_in > y_in) ? ogr_pkg::ERR_W'(y_in - ey_in)
                                                  : ogr_pkg::ERR_W'(ey_in - y_in);
                        err_next = dx_next + dy_next;
                        stamp_next = 1'b0;
                        state_next = S_WALK;
                    end
                end
            end
            S_READ:
            begin
                if (rd_in_reg)
                begin
                    value_next = mem_q_reg;
                    if (mem_q_reg > occ_level_reg)
                        class_next = ogr_pkg::CLASS_OCCUPIED;
                    else if (mem_q_reg < free_level_reg)
                        class_next = ogr_pkg::CLASS_FREE;
                    else
                        class_next = ogr_pkg::CLASS_UNKNOWN;
                end
                else
                begin
                    value_next = 16'sd0;
                    class_next = ogr_pkg::CLASS_UNKNOWN;
                end
                state_next = S_DONE;
            end
            S_WALK:
            begin
                if (x_reg == ex_reg && y_reg == ey_reg)
                begin
                    ox_next    = ogr_pkg::RAD_NEG;
                    oy_next    = ogr_pkg::RAD_NEG;
                    stamp_next = 1'b1;
                    state_next = hit_reg ? S_STAMP : S_DONE;
                end
                else
                begin
                    // Advance one Bresenham step
                    err_next = err_reg + ((e2 >= dy_reg) ? dy_reg : '0)
                                       + ((e2 <= dx_reg) ? dx_reg : '0);
                    if (e2 >= dy_reg)
                        x_next = sxn_reg ? x_reg - 1'b1 : x_reg + 1'b1;
                    if (e2 <= dx_reg)
                        y_next = syn_reg ? y_reg - 1'b1 : y_reg + 1'b1;
                    if (cell_in)
                    begin
                        mem_re     = 1'b1;
                        waddr_next = cell_addr;
                        rem_next   = cell_d2;
                        root_next  = '0;
                        bit_next   = ogr_pkg::D2_BITS'(1) << (ogr_pkg::D2_BITS - 2);
                        inc_next   = ogr_pkg::INC_W'(free_inc_reg);
                        state_next = S_SQRT;
                    end
                end
            end
            S_STAMP:
            begin
                if (oy_reg > ogr_pkg::RAD_POS)
                    state_next = S_DONE;
                else
                begin
                    if (ox_reg == ogr_pkg::RAD_POS)
                    begin
                        ox_next = ogr_pkg::RAD_NEG;
                        oy_next = oy_reg + 1'b1;
                    end
                    else
                        ox_next = ox_reg + 1'b1;
                    if (cell_in && wgt != 9'd0)
                    begin
                        mem_re     = 1'b1;
                        waddr_next = cell_addr;
                        rem_next   = cell_d2;
                        root_next  = '0;
                        bit_next   = ogr_pkg::D2_BITS'(1) << (ogr_pkg::D2_BITS - 2);
                        inc_next   = ogr_pkg::INC_W'(occ_inc_reg) * ogr_pkg::INC_W'(wgt_s);
                        state_next = S_SQRT;
                    end
                end
            end
            S_SQRT:
            begin
                // One result bit per cycle
                if (rem_reg >= trial)
                begin
                    rem_next  = rem_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                    root_next = root_reg >> 1;
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                    state_next = S_SCALE;
            end
            S_SCALE:
            begin
                scale_next = ogr_pkg::SCALE_ONE - ogr_pkg::SCALE_W'(dfd);
                state_next = S_MULT;
            end
            S_MULT:
            begin
                prod_next  = ogr_pkg::PROD_W'(inc_reg) * ogr_pkg::PROD_W'(scale_reg);
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                delta_next = ogr_pkg::DELTA_W'(shifted);
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                mem_we = 1'b1;
                if (touched_reg != 16'hFFFF)
                    touched_next = touched_reg + 1'b1;
                state_next = stamp_reg ? S_STAMP : S_WALK;
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.cell_value    = value_reg;
                    rsp_next.cell_class    = class_reg;
                    rsp_next.cells_touched = touched_reg;
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            rsp_valid_reg   <= 1'b0;
            free_inc_reg    <= -16'sd104;
            occ_inc_reg     <= 16'sd217;
            dist_factor_reg <= 16'd0;
            clamp_low_reg   <= -16'sd1280;
            clamp_high_reg  <= 15'd1280;
            gauss_reg       <= 64'd0;
            occ_level_reg   <= 16'sd216;
            free_level_reg  <= -16'sd216;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ogr_pkg::CFG_FREE_INC:   free_inc_reg    <= cfg_data[15:0];
                    ogr_pkg::CFG_OCC_INC:    occ_inc_reg     <= cfg_data[15:0];
                    ogr_pkg::CFG_DIST_FACT:  dist_factor_reg <= cfg_data[15:0];
                    ogr_pkg::CFG_CLAMP_LOW:  clamp_low_reg   <= cfg_data[15:0];
                    ogr_pkg::CFG_CLAMP_HIGH: clamp_high_reg  <= cfg_data[14:0];
                    ogr_pkg::CFG_GAUSS:      gauss_reg       <= cfg_data;
                    ogr_pkg::CFG_OCC_LEVEL:  occ_level_reg   <= cfg_data[15:0];
                    ogr_pkg::CFG_FREE_LEVEL: free_level_reg  <= cfg_data[15:0];
                    default:                 free_level_reg  <= free_level_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hit_reg     <= hit_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        ex_reg      <= ex_next;
        ey_reg      <= ey_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        err_reg     <= err_next;
        sxn_reg     <= sxn_next;
        syn_reg     <= syn_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        stamp_reg   <= stamp_next;
        rd_in_reg   <= rd_in_next;
        inc_reg     <= inc_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        bit_reg     <= bit_next;
        scale_reg   <= scale_next;
        prod_reg    <= prod_next;
        delta_reg   <= delta_next;
        waddr_reg   <= waddr_next;
        touched_reg <= touched_next;
        value_reg   <= value_next;
        class_reg   <= class_next;
        rsp_reg     <= rsp_next;
    end

    // Grid memory with a registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q_reg <= grid_mem[mem_raddr];
    end

    // Memory is only written by the clearing pass or the write-back step
    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_WRITE))
        else $error("grid write outside clear or write-back");

    // Each write-back advances the saturating touch count
    a_touch_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |=>
            (touched_reg == $past(touched_reg) + 16'd1 || $past(touched_reg) == 16'hFFFF))
        else $error("touch count did not advance on write-back");

    // Written values stay within ordered clamp limits
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && clamp_low_reg <= signed'({1'b0, clamp_high_reg})) |->
            (mem_wdata >= clamp_low_reg && mem_wdata <= signed'({1'b0, clamp_high_reg})))
        else $error("written cell outside clamp limits");

    // A new result only comes out of the finish step
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside finish step");

endmodule
`default_nettype wire
